/* hdl/prim_mst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package prim_mst_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int WEIGHT_BITS  = 16;
	localparam int VERT_BITS    = $clog2(MAX_VERTICES);
	localparam int VCNT_BITS    = $clog2(MAX_VERTICES + 1);
	localparam int COST_BITS    = 22;

	localparam int MAT_DEPTH    = 1 << (2 * VERT_BITS);
	localparam int EDGE_DEPTH   = MAX_VERTICES - 1;
	localparam int EDGE_AW      = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
	localparam int EDGE_W       = 2 * VERT_BITS + WEIGHT_BITS;

	localparam logic [WEIGHT_BITS-1:0] NO_EDGE    = '1;
	localparam logic [VCNT_BITS-1:0]   VCNT_RESET = VCNT_BITS'(MAX_VERTICES);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	typedef struct packed {
		logic mat_we;
		logic run_init;
		logic scan_init;
		logic scan_issue;
		logic commit;
		logic emit_next;
		logic emit_load;
		logic err_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic tree_full_next;
		logic emit_match;
		logic emit_final;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

/* hdl/prim_mst_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module prim_mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                                         clk,
	input  wire                                         we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                            wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/prim_mst_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_ctrl
// sequencer for load, matrix scan passes, edge commit, sorted emission and error
// ----------------------------------------------------------------------------
module prim_mst_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      mode,
	input  prim_mst_pkg::dp_status_t st,
	output prim_mst_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_DRAIN    = 3'd2;
	localparam logic [2:0] S_DECIDE   = 3'd3;
	localparam logic [2:0] S_ERR      = 3'd4;
	localparam logic [2:0] S_EMIT_RD  = 3'd5;
	localparam logic [2:0] S_EMIT_CHK = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == prim_mst_pkg::MODE_LOAD) begin
						cmd.mat_we = 1'b1;
					end else begin
						cmd.run_init  = 1'b1;
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!st.found) begin
					state_d = S_ERR;
				end else begin
					cmd.commit    = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = st.tree_full_next ? S_EMIT_RD : S_SCAN;
				end
			end
			S_ERR: begin
				if (st.out_free) begin
					cmd.err_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_CHK;
			end
			S_EMIT_CHK: begin
				if (st.emit_match) begin
					if (st.out_free) begin
						cmd.emit_load = 1'b1;
						if (st.emit_final) begin
							state_d = S_IDLE;
						end else begin
							cmd.emit_next = 1'b1;
							state_d       = S_EMIT_RD;
						end
					end
				end else begin
					cmd.emit_next = 1'b1;
					state_d       = S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/prim_mst_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_dp
// weight matrix, scan counters, best edge compare, tree flags, edge store
// and output register
// ----------------------------------------------------------------------------
module prim_mst_dp (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          cfg_we,
	input  wire  [prim_mst_pkg::VCNT_BITS-1:0]           cfg_wdata,
	input  wire  [prim_mst_pkg::VERT_BITS-1:0]           row,
	input  wire  [prim_mst_pkg::VERT_BITS-1:0]           col,
	input  wire  [prim_mst_pkg::WEIGHT_BITS-1:0]         weight,
	input  prim_mst_pkg::ctrl_cmd_t                      cmd,
	output prim_mst_pkg::dp_status_t                     st,
	output logic                                         out_valid,
	input  wire                                          out_ready,
	output logic [prim_mst_pkg::VERT_BITS-1:0]           edge_from,
	output logic [prim_mst_pkg::VERT_BITS-1:0]           edge_to,
	output logic [prim_mst_pkg::WEIGHT_BITS-1:0]         edge_weight,
	output logic [prim_mst_pkg::COST_BITS-1:0]           total_cost,
	output logic                                         last,
	output logic                                         no_edge_error
);

	localparam int VB = prim_mst_pkg::VERT_BITS;
	localparam int CB = prim_mst_pkg::VCNT_BITS;
	localparam int WB = prim_mst_pkg::WEIGHT_BITS;

	// configuration and run state
	logic [CB-1:0]                          vcount_q;
	logic [CB-1:0]                          n_q;
	logic [CB-1:0]                          n_clamp;
	logic [VB-1:0]                          nm1;
	logic [prim_mst_pkg::MAX_VERTICES-1:0]  in_tree_q;
	logic [VB-1:0]                          edge_count_q;
	logic [prim_mst_pkg::COST_BITS-1:0]     cost_q;

	// scan
	logic [VB-1:0] i_q, j_q;
	logic          elig;
	logic          valid_s1, elig_s1;
	logic [VB-1:0] i_s1, j_s1;
	logic [WB-1:0] mat_rdata;
	logic [WB-1:0] best_q;
	logic [VB-1:0] bu_q, bv_q;
	logic          found_q;

	// emission
	logic [VB-1:0]                      s_q, k_q, r_q;
	logic [prim_mst_pkg::EDGE_W-1:0]    edge_rdata;
	logic [VB-1:0]                      e_from, e_to;
	logic [WB-1:0]                      e_w;

	always_comb begin
		if (vcount_q < CB'(2)) begin
			n_clamp = CB'(2);
		end else if (vcount_q > CB'(prim_mst_pkg::MAX_VERTICES)) begin
			n_clamp = CB'(prim_mst_pkg::MAX_VERTICES);
		end else begin
			n_clamp = vcount_q;
		end
	end

	assign nm1 = VB'(n_q - CB'(1));

	assign elig = (i_q != j_q) &&
		((edge_count_q == '0) || (in_tree_q[i_q] && !in_tree_q[j_q]));

	prim_mst_ram #(
		.WIDTH(WB),
		.DEPTH(prim_mst_pkg::MAT_DEPTH)
	) u_mat_ram (
		.clk  (clk),
		.we   (cmd.mat_we),
		.waddr({row, col}),
		.wdata(weight),
		.raddr({i_q, j_q}),
		.rdata(mat_rdata)
	);

	prim_mst_ram #(
		.WIDTH(prim_mst_pkg::EDGE_W),
		.DEPTH(prim_mst_pkg::EDGE_DEPTH)
	) u_edge_ram (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(edge_count_q[prim_mst_pkg::EDGE_AW-1:0]),
		.wdata({bu_q, bv_q, best_q}),
		.raddr(k_q[prim_mst_pkg::EDGE_AW-1:0]),
		.rdata(edge_rdata)
	);

	assign e_from = edge_rdata[prim_mst_pkg::EDGE_W-1 -: VB];
	assign e_to   = edge_rdata[WB +: VB];
	assign e_w    = edge_rdata[WB-1:0];

	assign st.scan_last      = (i_q == nm1) && (j_q == nm1);
	assign st.found          = found_q;
	assign st.tree_full_next = (CB'(edge_count_q) + CB'(2)) == n_q;
	assign st.emit_match     = (e_from == s_q);
	assign st.emit_final     = (CB'(r_q) + CB'(1)) == CB'(edge_count_q);
	assign st.out_free       = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= prim_mst_pkg::VCNT_RESET;
			n_q          <= prim_mst_pkg::VCNT_RESET;
			in_tree_q    <= '0;
			edge_count_q <= '0;
			cost_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			valid_s1     <= 1'b0;
			found_q      <= 1'b0;
			s_q          <= '0;
			k_q          <= '0;
			r_q          <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (cmd.run_init) begin
				n_q          <= n_clamp;
				in_tree_q    <= '0;
				edge_count_q <= '0;
				cost_q       <= '0;
			end
			if (cmd.scan_init) begin
				i_q     <= '0;
				j_q     <= '0;
				found_q <= 1'b0;
				s_q     <= '0;
				k_q     <= '0;
				r_q     <= '0;
			end
			valid_s1 <= cmd.scan_issue;
			if (cmd.scan_issue) begin
				if (j_q == nm1) begin
					j_q <= '0;
					i_q <= i_q + VB'(1);
				end else begin
					j_q <= j_q + VB'(1);
				end
			end
			if (valid_s1 && elig_s1 && (mat_rdata < best_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				// the seed edge brings both of its vertices into the tree
				in_tree_q    <= in_tree_q | (prim_mst_pkg::MAX_VERTICES'(1) << bv_q)
					| ((edge_count_q == '0) ? (prim_mst_pkg::MAX_VERTICES'(1) << bu_q) : '0);
				edge_count_q <= edge_count_q + VB'(1);
				cost_q       <= cost_q + prim_mst_pkg::COST_BITS'(best_q);
			end
			if (cmd.emit_next) begin
				if (k_q == edge_count_q - VB'(1)) begin
					k_q <= '0;
					s_q <= s_q + VB'(1);
				end else begin
					k_q <= k_q + VB'(1);
				end
			end
			if (cmd.emit_load) begin
				r_q <= r_q + VB'(1);
			end
			if (cmd.emit_load || cmd.err_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		j_s1    <= j_q;
		elig_s1 <= elig;
		if (cmd.scan_init) begin
			best_q <= prim_mst_pkg::NO_EDGE;
		end else if (valid_s1 && elig_s1 && (mat_rdata < best_q)) begin
			best_q <= mat_rdata;
			bu_q   <= i_s1;
			bv_q   <= j_s1;
		end
		if (cmd.emit_load) begin
			edge_from     <= e_from;
			edge_to       <= e_to;
			edge_weight   <= e_w;
			total_cost    <= st.emit_final ? cost_q : '0;
			last          <= st.emit_final;
			no_edge_error <= 1'b0;
		end else if (cmd.err_load) begin
			edge_from     <= '0;
			edge_to       <= '0;
			edge_weight   <= '0;
			total_cost    <= '0;
			last          <= 1'b1;
			no_edge_error <= 1'b1;
		end
	end

	a_commit_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> found_q)
		else $error("edge committed without a candidate");

	a_commit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ((CB'(edge_count_q) + CB'(1)) < n_q))
		else $error("edge count past vertex count minus one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load || cmd.err_load) |-> (!out_valid || out_ready))
		else $error("output register overwritten before transaction");

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load && st.emit_final) |=> (out_valid && last && !no_edge_error))
		else $error("final edge not marked last");

endmodule
`default_nettype wire

/* hdl/prim_minimum_spanning_tree_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// prim minimum spanning tree over a stored adjacency matrix of weights
// ----------------------------------------------------------------------------
// load transactions: one per cycle while idle, straight into the weight ram
// run transaction: up to n-1 scan passes through the single read port of the
//   weight ram, then a sweep of the edge store for the sorted output, which
//   output stalls can hold up
// reset: controller idle, tree flags, counters and output valid cleared,
//   vertex_count back to 64; weight ram and edge store hold no reset value
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration: vertex count
	input  wire                                  cfg_we,
	input  wire  [prim_mst_pkg::VCNT_BITS-1:0]   cfg_wdata,
	// input channel
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  mode,
	input  wire  [prim_mst_pkg::VERT_BITS-1:0]   row,
	input  wire  [prim_mst_pkg::VERT_BITS-1:0]   col,
	input  wire  [prim_mst_pkg::WEIGHT_BITS-1:0] weight,
	// output channel
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [prim_mst_pkg::VERT_BITS-1:0]   edge_from,
	output logic [prim_mst_pkg::VERT_BITS-1:0]   edge_to,
	output logic [prim_mst_pkg::WEIGHT_BITS-1:0] edge_weight,
	output logic [prim_mst_pkg::COST_BITS-1:0]   total_cost,
	output logic                                 last,
	output logic                                 no_edge_error
);

	// commands from the sequencer, status back from the datapath
	prim_mst_pkg::ctrl_cmd_t  cmd;
	prim_mst_pkg::dp_status_t st;

	// sequencer: idle/load, scan passes, commit, sorted emission, error
	prim_mst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode    (mode),
		.st      (st),
		.cmd     (cmd)
	);

	// datapath: weight ram, best edge search, edge store, output register
	// the output register lets a new transaction be taken while a result waits
	prim_mst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.row          (row),
		.col          (col),
		.weight       (weight),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.edge_weight  (edge_weight),
		.total_cost   (total_cost),
		.last         (last),
		.no_edge_error(no_edge_error)
	);

endmodule
`default_nettype wire
